>>> hdl/mtlfr_pkg.sv
// ----------------------------------------------------------------------------
// mtlfr_pkg
// Shared types and constants for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package mtlfr_pkg;

  // payload buffer geometry
  localparam int unsigned BufferDepth = 64;
  localparam int unsigned IdxW        = $clog2(BufferDepth);
  // hard ceiling on a frame length: one entry short of the buffer
  localparam logic [7:0]  LimitMax    = 8'(BufferDepth - 1);

  // configuration port
  localparam int unsigned CfgAddrW    = 3;
  localparam logic [7:0]  MagicReset  = 8'hEF;
  localparam logic [5:0]  MaxPayReset = 6'd63;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_MAGIC = 1'b0,
    REG_MAXPAY = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_OVERLOAD   = 2'd1,
    KIND_UNEXPECTED = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_TOKEN,
    ST_LENGTH,
    ST_CONTENT,
    ST_PRIME,
    ST_STREAM,
    ST_HALT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic  restart;
    logic  cap_token;
    logic  cap_length;
    logic  wr_en;
    logic  err;
    kind_e err_kind;
    logic  rd_start;
    logic  rd_next;
    logic  stream_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_is_magic;
    logic len_over;
    logic fill_over;
    logic fill_last;
    logic stream_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/mtlfr_ram.sv
// ----------------------------------------------------------------------------
// mtlfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtlfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mtlfr_regs.sv
// ----------------------------------------------------------------------------
// mtlfr_regs
// APB-style configuration registers: magic byte and payload limit.
// ----------------------------------------------------------------------------
module mtlfr_regs
  import mtlfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [7:0]          magic_o,
  output logic [5:0]          max_pay_o
);

  logic       wr;
  reg_idx_e   idx;
  logic [7:0] magic_q, magic_d;
  logic [5:0] max_pay_q, max_pay_d;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  // registers sit on a 4-byte stride, bit 2 picks one
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    magic_d   = magic_q;
    max_pay_d = max_pay_q;
    if (wr) begin
      case (idx)
        REG_MAGIC:  magic_d   = pwdata[7:0];
        REG_MAXPAY: max_pay_d = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAGIC:  prdata = {24'd0, magic_q};
      REG_MAXPAY: prdata = {26'd0, max_pay_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MagicReset;
      max_pay_q <= MaxPayReset;
    end else begin
      magic_q   <= magic_d;
      max_pay_q <= max_pay_d;
    end
  end

  assign magic_o   = magic_q;
  assign max_pay_o = max_pay_q;

endmodule

>>> hdl/mtlfr_ctrl.sv
// ----------------------------------------------------------------------------
// mtlfr_ctrl
// Frame parser and payload readout sequencer.
// ----------------------------------------------------------------------------
module mtlfr_ctrl
  import mtlfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      op_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // no input while the buffer drains or the output word is blocked
  assign in_stall_o = (state_q == ST_PRIME) || (state_q == ST_STREAM) || !stat_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_HUNT: begin
        if (accept) state_d = stat_i.byte_is_magic ? ST_TOKEN : ST_HALT;
      end
      ST_TOKEN: begin
        if (accept) state_d = ST_LENGTH;
      end
      ST_LENGTH: begin
        if (accept) state_d = stat_i.len_over ? ST_HALT : ST_CONTENT;
      end
      ST_CONTENT: begin
        if (accept) begin
          if (stat_i.fill_over)      state_d = ST_HALT;
          else if (stat_i.fill_last) state_d = ST_PRIME;
        end
      end
      ST_PRIME:  state_d = ST_STREAM;
      ST_STREAM: begin
        if (stat_i.out_free && stat_i.stream_last) state_d = ST_HALT;
      end
      ST_HALT: ;
      default:   state_d = ST_HALT;
    endcase
    // restart wins in any state that takes input
    if (accept && op_i) state_d = ST_HUNT;
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.err_kind = KIND_DATA;
    case (state_q)
      ST_HUNT: begin
        if (accept && !op_i && !stat_i.byte_is_magic) begin
          cmd_o.err      = 1'b1;
          cmd_o.err_kind = KIND_UNEXPECTED;
        end
      end
      ST_TOKEN: begin
        cmd_o.cap_token = accept && !op_i;
      end
      ST_LENGTH: begin
        if (accept && !op_i) begin
          cmd_o.cap_length = 1'b1;
          if (stat_i.len_over) begin
            cmd_o.err      = 1'b1;
            cmd_o.err_kind = KIND_OVERLOAD;
          end
        end
      end
      ST_CONTENT: begin
        if (accept && !op_i) begin
          if (stat_i.fill_over) begin
            cmd_o.err      = 1'b1;
            cmd_o.err_kind = KIND_OVERLOAD;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_PRIME:  cmd_o.rd_start = 1'b1;
      ST_STREAM: begin
        if (stat_i.out_free) begin
          cmd_o.stream_load = 1'b1;
          cmd_o.rd_next     = !stat_i.stream_last;
        end
      end
      ST_HALT: ;
      default: ;
    endcase
    cmd_o.restart = accept && op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/mtlfr_dp.sv
// ----------------------------------------------------------------------------
// mtlfr_dp
// Frame registers, payload buffer, readout counter and output word register.
// ----------------------------------------------------------------------------
module mtlfr_dp
  import mtlfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] magic_i,
  input  logic [5:0] max_pay_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_stat_t   stat_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] frame_token_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] frame_length_o,
  output logic       last_o
);

  logic [7:0]      tok_q, tok_d;
  logic [7:0]      len_q, len_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] raddr;
  logic [7:0]      rdata;
  logic [7:0]      lim;
  logic [7:0]      max_pay_ext;
  logic            out_valid_q, out_valid_d;
  logic            load;

  kind_e      kind_q;
  logic [7:0] otok_q, obyte_q, olen_q;
  logic [5:0] oidx_q;
  logic       olast_q;

  // effective length limit: register value capped at LimitMax, one entry short of the buffer
  assign max_pay_ext = 8'(max_pay_i);
  assign lim         = (max_pay_ext > LimitMax) ? LimitMax : max_pay_ext;

  assign stat_o.byte_is_magic = (rx_byte_i == magic_i);
  assign stat_o.len_over      = (rx_byte_i > lim);
  assign stat_o.fill_over     = (8'(fill_q) >= len_q) || (8'(fill_q) == LimitMax);
  assign stat_o.fill_last     = ((8'(fill_q) + 8'd1) == len_q);
  assign stat_o.stream_last   = ((8'(rd_idx_q) + 8'd1) == len_q);
  assign stat_o.out_free      = !out_valid_q || !out_stall_i;

  always_comb begin
    tok_d    = tok_q;
    len_d    = len_q;
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.restart) begin
      tok_d  = '0;
      len_d  = '0;
      fill_d = '0;
    end
    if (cmd_i.cap_token)  tok_d  = rx_byte_i;
    if (cmd_i.cap_length) len_d  = rx_byte_i;
    if (cmd_i.wr_en)      fill_d = fill_q + IdxW'(1);
    if (cmd_i.rd_start)   rd_idx_d = '0;
    else if (cmd_i.rd_next) rd_idx_d = rd_idx_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      len_q       <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tok_q       <= tok_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // read one entry ahead of the output word
  assign raddr = cmd_i.rd_start ? '0 : (rd_idx_q + IdxW'(1));

  mtlfr_ram #(
    .Width(8),
    .Depth(BufferDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(fill_q),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_start | cmd_i.rd_next),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign load        = cmd_i.err | cmd_i.stream_load;
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.err) begin
      kind_q  <= cmd_i.err_kind;
      otok_q  <= tok_q;
      obyte_q <= '0;
      oidx_q  <= '0;
      olen_q  <= cmd_i.cap_length ? rx_byte_i : len_q;
      olast_q <= 1'b1;
    end else if (cmd_i.stream_load) begin
      kind_q  <= KIND_DATA;
      otok_q  <= tok_q;
      obyte_q <= rdata;
      oidx_q  <= 6'(rd_idx_q);
      olen_q  <= len_q;
      olast_q <= stat_o.stream_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign frame_token_o  = otok_q;
  assign payload_byte_o = obyte_q;
  assign byte_index_o   = oidx_q;
  assign frame_length_o = olen_q;
  assign last_o         = olast_q;

endmodule

>>> hdl/magic_token_length_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// magic_token_length_frame_receiver_top
// Parses magic / token / length / payload frames from a byte stream and
// plays the buffered payload back as a run of words.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake               payload
//   -------  ---  ----------------------  -----------------------------------
//   in       in   in_valid_i / in_stall_o op_i, rx_byte_i
//   out      out  out_valid_o/out_stall_i kind_o, frame_token_o,
//                                         payload_byte_o, byte_index_o,
//                                         frame_length_o, last_o
//   cfg      in   psel/penable, pready=1  paddr, pwdata, prdata
//
// Timing:
//   - A header or payload byte, restart or ignored byte is taken whenever input is not stalled.
//   - The byte that completes a frame of N bytes starts a readout of N words:
//     the buffer's registered read port is primed first, then one word per
//     cycle while out_stall_i is low. Input is stalled meanwhile.
//   - An error word is loaded in the cycle its byte is accepted.
//   - Input stalls only while a word in the output register is itself stalled,
//     or during readout. No clearing pass after reset: buffer entries are
//     always written before they are read.
//
// After an error or a delivered frame the receiver stays halted and drops
// bytes until an item with op_i set restarts it.
// ----------------------------------------------------------------------------
module magic_token_length_frame_receiver_top
  import mtlfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [7:0]          rx_byte_i,
  // output words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          frame_token_o,
  output logic [7:0]          payload_byte_o,
  output logic [5:0]          byte_index_o,
  output logic [7:0]          frame_length_o,
  output logic                last_o
);

  logic [7:0] magic;
  logic [5:0] max_pay;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;

  mtlfr_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .magic_o  (magic),
    .max_pay_o(max_pay)
  );

  // parse state machine and readout sequencing
  mtlfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .op_i      (op_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // frame registers, payload buffer and output word
  mtlfr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .magic_i       (magic),
    .max_pay_i     (max_pay),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .frame_token_o (frame_token_o),
    .payload_byte_o(payload_byte_o),
    .byte_index_o  (byte_index_o),
    .frame_length_o(frame_length_o),
    .last_o        (last_o)
  );

endmodule

>>> hdl/mtlfr_checker.sv
// ----------------------------------------------------------------------------
// mtlfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module mtlfr_checker
  import mtlfr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] payload_byte_o,
  input logic [5:0] byte_index_o,
  input logic       last_o
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // error words stand alone, with zero byte and index
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_DATA) |->
      last_o && (payload_byte_o == 8'd0) && (byte_index_o == 6'd0))
    else $error("malformed error word");

  // readout runs back to back with rising index
  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == KIND_DATA) && !last_o |=>
      out_valid_o && (kind_o == KIND_DATA) &&
      (byte_index_o == 6'($past(byte_index_o) + 6'd1)))
    else $error("payload run broken");

  // no input taken in the middle of a payload run
  a_run_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA) && !last_o |-> in_stall_o)
    else $error("input accepted during payload run");

endmodule

bind magic_token_length_frame_receiver_top mtlfr_checker u_chk (.*);
